// ===== sv/uoft_pkg.sv =====
package uoft_pkg;

    localparam int MaxRes  = 4;
    localparam int ResIdxW = $clog2(MaxRes);
    localparam int ResCntW = $clog2(MaxRes + 1);

    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_QM    = 8'h3F;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [4:0] HEX_BAD = 5'd16;

    localparam logic [11:0] CNT_MAX = 12'd4095;

    localparam logic [1:0] KIND_PATH  = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_ORIGIN = 2'd1;
    localparam logic [1:0] ST_PATH_LONG  = 2'd2;
    localparam logic [1:0] ST_QUERY_LONG = 2'd3;

    localparam logic [1:0] CFG_MAX_PATH  = 2'd0;
    localparam logic [1:0] CFG_MAX_QUERY = 2'd1;
    localparam logic [1:0] CFG_MAX_PAIRS = 2'd2;

    localparam logic [11:0] CFG_RST_PATH  = 12'd511;
    localparam logic [11:0] CFG_RST_QUERY = 12'd1023;
    localparam logic [5:0]  CFG_RST_PAIRS = 6'd32;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] field_kind;
        logic       field_end;
        logic       url_end;
        logic [1:0] status;
    } t_res_beat;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [11:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0] tok_byte;
        logic       has;
        logic [1:0] kind;
        logic       fend;
    } t_tok;

    typedef struct packed {
        t_tok [MaxRes-1:0]  toks;
        logic [ResIdxW-1:0] last_idx;
        logic               url_end;
        logic [1:0]         status;
    } t_bundle;

endpackage

// ===== sv/uoft_front.sv =====
module uoft_front import uoft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_beat i_in,
    input  logic     i_q_full,
    input  t_cfg_wr  i_cfg,
    output logic     o_q_push,
    output t_bundle  o_bundle
);

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_PATH  = 6'b000010,
        PH_KEY   = 6'b000100,
        PH_VALUE = 6'b001000,
        PH_DROP  = 6'b010000,
        PH_ERR   = 6'b100000
    } t_phase;

    typedef struct packed {
        t_tok [MaxRes-1:0]  toks;
        logic [ResCntW-1:0] n;
        logic [1:0]         pc;
        logic [7:0]         pb;
    } t_work;

    function automatic logic [4:0] f_hex(logic [7:0] b);
        logic [4:0] h;
        h = HEX_BAD;
        if (b inside {[8'h30:8'h39]}) begin
            h = {1'b0, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h = {1'b0, b[3:0] + 4'd9};
        end
        return h;
    endfunction

    function automatic t_work f_emit(t_work w, logic [1:0] kind, logic [7:0] byt);
        t_work r;
        r = w;
        if (r.n < ResCntW'(MaxRes)) begin
            r.toks[r.n[ResIdxW-1:0]] = '{tok_byte: byt, has: 1'b1, kind: kind, fend: 1'b0};
            r.n = r.n + ResCntW'(1);
        end
        return r;
    endfunction

    function automatic t_work f_end(t_work w, logic [1:0] kind);
        t_work              r;
        logic [ResIdxW-1:0] li;
        r  = w;
        li = ResIdxW'(r.n - ResCntW'(1));
        if (r.n != '0 && r.toks[li].has && r.toks[li].kind == kind && !r.toks[li].fend) begin
            r.toks[li].fend = 1'b1;
        end else if (r.n < ResCntW'(MaxRes)) begin
            r.toks[r.n[ResIdxW-1:0]] = '{tok_byte: 8'h00, has: 1'b0, kind: kind, fend: 1'b1};
            r.n = r.n + ResCntW'(1);
        end
        return r;
    endfunction

    function automatic t_work f_flush(t_work w, logic [1:0] kind);
        t_work r;
        r = w;
        if (r.pc >= 2'd1) r = f_emit(r, kind, C_PCT);
        if (r.pc >= 2'd2) r = f_emit(r, kind, r.pb);
        r.pc = 2'd0;
        return r;
    endfunction

    function automatic t_work f_feed(t_work w, logic [1:0] kind, logic [7:0] b);
        t_work      r;
        logic [4:0] h;
        logic [4:0] hp;
        logic       done;
        r    = w;
        h    = f_hex(b);
        hp   = f_hex(w.pb);
        done = 1'b0;
        if (r.pc == 2'd1) begin
            if (!h[4]) begin
                r.pb = b;
                r.pc = 2'd2;
                done = 1'b1;
            end else begin
                r = f_flush(r, kind);
            end
        end else if (r.pc >= 2'd2) begin
            if (!h[4]) begin
                r    = f_emit(r, kind, {hp[3:0], h[3:0]});
                r.pc = 2'd0;
                done = 1'b1;
            end else begin
                r = f_flush(r, kind);
            end
        end
        if (!done) begin
            if (b == C_PCT) begin
                r.pc = 2'd1;
            end else begin
                r = f_emit(r, kind, b);
            end
        end
        return r;
    endfunction

    logic [11:0] r_max_path;
    logic [11:0] r_max_query;
    logic [5:0]  r_max_pairs;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_pc;
    logic [7:0]  r_pb;
    logic [11:0] r_path, n_path;
    logic [11:0] r_query, n_query;
    logic [5:0]  r_pairs, n_pairs;
    logic        r_nonempty, n_nonempty;
    logic [1:0]  r_err, n_err;

    t_work       v;
    logic        accept;
    logic [7:0]  b;
    logic [11:0] q_inc;

    assign accept = i_push && !i_q_full;
    assign b      = i_in.in_byte;
    assign q_inc  = (r_query != CNT_MAX) ? r_query + 12'd1 : r_query;

    always_comb begin
        v.toks     = '0;
        v.n        = '0;
        v.pc       = r_pc;
        v.pb       = r_pb;
        n_phase    = r_phase;
        n_path     = r_path;
        n_query    = r_query;
        n_pairs    = r_pairs;
        n_nonempty = r_nonempty;
        n_err      = r_err;
        case (r_phase)
            PH_START: begin
                if (b != C_SLASH) begin
                    n_err   = ST_NOT_ORIGIN;
                    n_phase = PH_ERR;
                end else begin
                    n_path  = 12'd1;
                    n_phase = PH_PATH;
                    v       = f_feed(v, KIND_PATH, b);
                end
            end
            PH_PATH: begin
                if (b == C_QM) begin
                    if (r_path > r_max_path) begin
                        n_err   = ST_PATH_LONG;
                        n_phase = PH_ERR;
                    end else begin
                        v          = f_flush(v, KIND_PATH);
                        v          = f_end(v, KIND_PATH);
                        n_phase    = PH_KEY;
                        n_nonempty = 1'b0;
                    end
                end else begin
                    if (r_path != CNT_MAX) n_path = r_path + 12'd1;
                    v = f_feed(v, KIND_PATH, b);
                end
            end
            PH_KEY, PH_VALUE, PH_DROP: begin
                n_query = q_inc;
                if (q_inc > r_max_query) begin
                    n_err   = ST_QUERY_LONG;
                    n_phase = PH_ERR;
                    v.pc    = 2'd0;
                end else if (r_phase == PH_KEY) begin
                    if (!r_nonempty && b == C_AMP) begin
                        n_nonempty = 1'b0;
                    end else if (!r_nonempty && r_pairs >= r_max_pairs) begin
                        n_phase = PH_DROP;
                    end else begin
                        if (!r_nonempty) begin
                            n_pairs    = r_pairs + 6'd1;
                            n_nonempty = 1'b1;
                        end
                        if (b == C_AMP) begin
                            v          = f_flush(v, KIND_KEY);
                            v          = f_end(v, KIND_KEY);
                            v          = f_end(v, KIND_VALUE);
                            n_nonempty = 1'b0;
                        end else if (b == C_EQ) begin
                            v       = f_flush(v, KIND_KEY);
                            v       = f_end(v, KIND_KEY);
                            n_phase = PH_VALUE;
                        end else begin
                            v = f_feed(v, KIND_KEY, b);
                        end
                    end
                end else if (r_phase == PH_VALUE) begin
                    if (b == C_AMP) begin
                        v          = f_flush(v, KIND_VALUE);
                        v          = f_end(v, KIND_VALUE);
                        n_phase    = PH_KEY;
                        n_nonempty = 1'b0;
                    end else begin
                        v = f_feed(v, KIND_VALUE, b);
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (i_in.in_last) begin
            if (n_phase == PH_PATH) begin
                v = f_flush(v, KIND_PATH);
                v = f_end(v, KIND_PATH);
            end else if (n_phase == PH_KEY && n_nonempty) begin
                v = f_flush(v, KIND_KEY);
                v = f_end(v, KIND_KEY);
                v = f_end(v, KIND_VALUE);
            end else if (n_phase == PH_VALUE) begin
                v = f_flush(v, KIND_VALUE);
                v = f_end(v, KIND_VALUE);
            end
            if (v.n == '0) v.n = ResCntW'(1);
        end
    end

    assign o_q_push          = accept && (v.n != '0);
    assign o_bundle.toks     = v.toks;
    assign o_bundle.last_idx = ResIdxW'(v.n - ResCntW'(1));
    assign o_bundle.url_end  = i_in.in_last;
    assign o_bundle.status   = n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_path  <= CFG_RST_PATH;
            r_max_query <= CFG_RST_QUERY;
            r_max_pairs <= CFG_RST_PAIRS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MAX_PATH:  r_max_path  <= i_cfg.data;
                CFG_MAX_QUERY: r_max_query <= i_cfg.data;
                CFG_MAX_PAIRS: r_max_pairs <= i_cfg.data[5:0];
                default:       r_max_path  <= r_max_path;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_pc       <= 2'd0;
            r_path     <= '0;
            r_query    <= '0;
            r_pairs    <= '0;
            r_nonempty <= 1'b0;
            r_err      <= ST_OK;
        end else if (accept) begin
            if (i_in.in_last) begin
                r_phase    <= PH_START;
                r_pc       <= 2'd0;
                r_path     <= '0;
                r_query    <= '0;
                r_pairs    <= '0;
                r_nonempty <= 1'b0;
                r_err      <= ST_OK;
            end else begin
                r_phase    <= n_phase;
                r_pc       <= v.pc;
                r_path     <= n_path;
                r_query    <= n_query;
                r_pairs    <= n_pairs;
                r_nonempty <= n_nonempty;
                r_err      <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pb <= v.pb;
        end
    end

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_START |-> (r_pc == 2'd0 && r_err == ST_OK && r_pairs == '0))
        else $error("front: dirty state at start of URL");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.in_last |=> r_phase == PH_START)
        else $error("front: phase not back to start after last beat");

endmodule

// ===== sv/uoft_queue.sv =====
module uoft_queue import uoft_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_bundle o_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_bundle           r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_cnt;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + PtrW'(1);
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + CntW'(1);
                2'b01:   r_cnt <= r_cnt - CntW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue: push while full");

endmodule

// ===== sv/uoft_back.sv =====
module uoft_back import uoft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_bundle   i_head,
    output logic      o_head_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_res_beat o_res
);

    logic               r_valid;
    logic [ResIdxW-1:0] r_idx;
    t_res_beat          r_res;
    logic               load;
    logic               at_last;
    t_tok               tok;

    assign load       = i_head_valid && (!r_valid || i_pop);
    assign at_last    = (r_idx == i_head.last_idx);
    assign tok        = i_head.toks[r_idx];
    assign o_head_pop = load && at_last;
    assign o_empty    = !r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_last ? '0 : r_idx + ResIdxW'(1);
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res.out_byte   <= tok.tok_byte;
            r_res.has_byte   <= tok.has;
            r_res.field_kind <= tok.kind;
            r_res.field_end  <= tok.fend;
            r_res.url_end    <= i_head.url_end && at_last;
            r_res.status     <= i_head.status;
        end
    end

    a_mid_bundle_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != '0 |-> i_head_valid)
        else $error("back: bundle left queue before all beats sent");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> r_idx <= i_head.last_idx)
        else $error("back: beat index past end of bundle");

endmodule

// ===== sv/url_origin_form_tokenizer_unit.sv =====
// Each result beat passes through the bundle queue and the output register to o_res.
// Throughput: one input beat per cycle while each beat yields at most one result
// and pop is held; a beat yielding k results (k up to 4) holds the single output
// register for k beats, the QUEUE_DEPTH-entry bundle queue absorbing the difference.
// Reset: synchronous, active low; clears URL state, empties queues, restores limits.
module url_origin_form_tokenizer_unit import uoft_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in_beat    i_in,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output t_res_beat   o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_cfg_wr cfg;
    logic    q_push;
    t_bundle q_in;
    logic    q_valid;
    t_bundle q_head;
    logic    q_pop;
    logic    q_full;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;
    assign full        = q_full;

    uoft_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_in     (i_in),
        .i_q_full (q_full),
        .i_cfg    (cfg),
        .o_q_push (q_push),
        .o_bundle (q_in)
    );

    uoft_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    uoft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_head_pop   (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_res        (o_res)
    );

endmodule

// ===== sim/tb_url_origin_form_tokenizer_unit.sv =====
`timescale 1ns / 1ps

module tb_url_origin_form_tokenizer_unit import uoft_pkg::*;;

    typedef enum logic [2:0] {
        PS_START,
        PS_PATH,
        PS_KEY,
        PS_VALUE,
        PS_DROP,
        PS_ERR
    } t_parse;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    t_in_beat    i_in = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    t_res_beat   o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_MAX_PATH;
    logic [11:0] i_cfg_data = '0;

    url_origin_form_tokenizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_in        (i_in),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_in_beat  url_stream[$];
    t_res_beat tokens_due[$];
    t_res_beat want_tok;

    bit steady = 1'b0;
    bit byte_taken = 1'b0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int tokens_checked = 0;
    int urls_seen = 0;
    int urls_rejected = 0;
    int mismatches = 0;

    logic [11:0] lim_path = CFG_RST_PATH;
    logic [11:0] lim_query = CFG_RST_QUERY;
    logic [5:0]  lim_pairs = CFG_RST_PAIRS;

    t_parse      parse_st = PS_START;
    logic [1:0]  held_n = '0;
    logic [7:0]  held_digit = '0;
    logic [11:0] path_len = '0;
    logic [11:0] query_len = '0;
    logic [5:0]  pair_n = '0;
    logic        part_open = 1'b0;
    logic [1:0]  err_code = ST_OK;
    t_res_beat   tok_buf[MaxRes];
    int          tok_n = 0;

    task automatic note_mismatch(string what, int got, int want);
        mismatches++;
        $display("%0t: token %0d %s: got 0x%0h, want 0x%0h",
                 $time, tokens_checked, what, got, want);
    endtask

    function automatic logic [4:0] hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return HEX_BAD;
    endfunction

    function automatic void put_byte(logic [1:0] kind, logic [7:0] b);
        if (tok_n >= MaxRes) return;
        tok_buf[tok_n] = {b, 1'b1, kind, 1'b0, 1'b0, ST_OK};
        tok_n++;
    endfunction

    function automatic void close_field(logic [1:0] kind);
        if (tok_n > 0 && tok_buf[tok_n - 1].has_byte && tok_buf[tok_n - 1].field_kind == kind
                && !tok_buf[tok_n - 1].field_end) begin
            tok_buf[tok_n - 1].field_end = 1'b1;
            return;
        end
        if (tok_n >= MaxRes) return;
        tok_buf[tok_n] = {8'h00, 1'b0, kind, 1'b1, 1'b0, ST_OK};
        tok_n++;
    endfunction

    function automatic void flush_held(logic [1:0] kind);
        if (held_n >= 2'd1) put_byte(kind, C_PCT);
        if (held_n >= 2'd2) put_byte(kind, held_digit);
        held_n = 2'd0;
    endfunction

    function automatic void feed_char(logic [1:0] kind, logic [7:0] b);
        logic [4:0] lo;
        logic [4:0] hi;
        lo = hex_value(b);
        if (held_n == 2'd1) begin
            if (lo != HEX_BAD) begin
                held_digit = b;
                held_n = 2'd2;
                return;
            end
            flush_held(kind);
        end else if (held_n == 2'd2) begin
            if (lo != HEX_BAD) begin
                hi = hex_value(held_digit);
                put_byte(kind, {hi[3:0], lo[3:0]});
                held_n = 2'd0;
                return;
            end
            flush_held(kind);
        end
        if (b == C_PCT) held_n = 2'd1;
        else put_byte(kind, b);
    endfunction

    function automatic void tokenize_byte(logic [7:0] b, logic fin);
        t_res_beat t;
        int k;
        tok_n = 0;
        case (parse_st)
            PS_START: begin
                if (b != C_SLASH) begin
                    err_code = ST_NOT_ORIGIN;
                    parse_st = PS_ERR;
                end else begin
                    path_len = 12'd1;
                    parse_st = PS_PATH;
                    feed_char(KIND_PATH, b);
                end
            end
            PS_PATH: begin
                if (b == C_QM) begin
                    if (path_len > lim_path) begin
                        err_code = ST_PATH_LONG;
                        parse_st = PS_ERR;
                    end else begin
                        flush_held(KIND_PATH);
                        close_field(KIND_PATH);
                        parse_st = PS_KEY;
                        part_open = 1'b0;
                    end
                end else begin
                    if (path_len < CNT_MAX) path_len++;
                    feed_char(KIND_PATH, b);
                end
            end
            PS_KEY, PS_VALUE, PS_DROP: begin
                if (query_len < CNT_MAX) query_len++;
                if (query_len > lim_query) begin
                    err_code = ST_QUERY_LONG;
                    parse_st = PS_ERR;
                    held_n = 2'd0;
                end else if (parse_st == PS_VALUE) begin
                    if (b == C_AMP) begin
                        flush_held(KIND_VALUE);
                        close_field(KIND_VALUE);
                        parse_st = PS_KEY;
                        part_open = 1'b0;
                    end else begin
                        feed_char(KIND_VALUE, b);
                    end
                end else if (parse_st == PS_KEY && !(b == C_AMP && !part_open)) begin
                    if (!part_open && pair_n >= lim_pairs) begin
                        parse_st = PS_DROP;
                    end else begin
                        if (!part_open) begin
                            pair_n++;
                            part_open = 1'b1;
                        end
                        if (b == C_AMP) begin
                            flush_held(KIND_KEY);
                            close_field(KIND_KEY);
                            close_field(KIND_VALUE);
                            part_open = 1'b0;
                        end else if (b == C_EQ) begin
                            flush_held(KIND_KEY);
                            close_field(KIND_KEY);
                            parse_st = PS_VALUE;
                        end else begin
                            feed_char(KIND_KEY, b);
                        end
                    end
                end
            end
            default: ;
        endcase

        if (fin) begin
            if (parse_st == PS_PATH) begin
                flush_held(KIND_PATH);
                close_field(KIND_PATH);
            end else if (parse_st == PS_KEY && part_open) begin
                flush_held(KIND_KEY);
                close_field(KIND_KEY);
                close_field(KIND_VALUE);
            end else if (parse_st == PS_VALUE) begin
                flush_held(KIND_VALUE);
                close_field(KIND_VALUE);
            end
            if (tok_n == 0) begin
                tok_buf[0] = {8'h00, 1'b0, KIND_PATH, 1'b0, 1'b0, ST_OK};
                tok_n = 1;
            end
        end

        for (k = 0; k < tok_n; k++) begin
            t = tok_buf[k];
            t.url_end = fin && (k == tok_n - 1);
            t.status = err_code;
            tokens_due.push_back(t);
        end

        if (fin) begin
            urls_seen++;
            if (err_code != ST_OK) urls_rejected++;
            parse_st = PS_START;
            held_n = 2'd0;
            held_digit = 8'h00;
            path_len = '0;
            query_len = '0;
            pair_n = '0;
            part_open = 1'b0;
            err_code = ST_OK;
        end
    endfunction

    always @(posedge i_clk) begin
        byte_taken = i_rst_n && push && !full;
        if (i_rst_n) begin
            if (!empty && pop) begin
                if (tokens_due.size() == 0) begin
                    note_mismatch("token with none predicted", int'(o_res), 0);
                end else begin
                    want_tok = tokens_due.pop_front();
                    if (o_res.out_byte !== want_tok.out_byte)
                        note_mismatch("out_byte", int'(o_res.out_byte),
                                      int'(want_tok.out_byte));
                    if (o_res.has_byte !== want_tok.has_byte)
                        note_mismatch("has_byte", int'(o_res.has_byte),
                                      int'(want_tok.has_byte));
                    if (o_res.field_kind !== want_tok.field_kind)
                        note_mismatch("field_kind", int'(o_res.field_kind),
                                      int'(want_tok.field_kind));
                    if (o_res.field_end !== want_tok.field_end)
                        note_mismatch("field_end", int'(o_res.field_end),
                                      int'(want_tok.field_end));
                    if (o_res.url_end !== want_tok.url_end)
                        note_mismatch("url_end", int'(o_res.url_end),
                                      int'(want_tok.url_end));
                    if (o_res.status !== want_tok.status)
                        note_mismatch("status", int'(o_res.status),
                                      int'(want_tok.status));
                    tokens_checked++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_PATH:  lim_path = i_cfg_data;
                    CFG_MAX_QUERY: lim_query = i_cfg_data;
                    CFG_MAX_PAIRS: lim_pairs = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (byte_taken) begin
                tokenize_byte(i_in.in_byte, i_in.in_last);
                bytes_taken++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (byte_taken || !push) begin
            if (url_stream.size() != 0 && (steady || $urandom_range(0, 99) >= 13)) begin
                push <= 1'b1;
                i_in <= url_stream.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        pop <= i_rst_n && (steady || $urandom_range(0, 99) >= 13);
    end

    task automatic add_byte(logic [7:0] b, logic fin);
        url_stream.push_back({b, fin});
        bytes_queued++;
    endtask

    task automatic add_text(string s);
        int k;
        for (k = 0; k < s.len(); k++) add_byte(s[k], k == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        string hexd;
        hexd = "0123456789abcdefABCDEF";
        r = $urandom_range(0, 99);
        if (r < 10) return C_PCT;
        if (r < 28) return hexd[$urandom_range(0, 21)];
        if (r < 36) return C_AMP;
        if (r < 43) return C_EQ;
        if (r < 46) return C_QM;
        if (r < 58) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    task automatic add_random_url(int path_max, int query_max);
        logic [7:0] txt[$];
        logic [7:0] c;
        int n;
        int k;
        if ($urandom_range(0, 99) < 80) begin
            txt.push_back(C_SLASH);
            n = $urandom_range(0, path_max);
            for (k = 0; k < n; k++) begin
                c = pick_char();
                txt.push_back(c == C_QM ? 8'h78 : c);
            end
            txt.push_back(C_QM);
            n = $urandom_range(0, query_max);
            for (k = 0; k < n; k++) txt.push_back(pick_char());
        end else begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++) txt.push_back(pick_char());
        end
        for (k = 0; k < txt.size(); k++) add_byte(txt[k], k == txt.size() - 1);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        while ((bytes_taken != bytes_queued || tokens_due.size() != 0) && waited < 50000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(logic [11:0] p, logic [11:0] q, logic [5:0] n);
        write_reg(CFG_MAX_PATH, p);
        write_reg(CFG_MAX_QUERY, q);
        write_reg(CFG_MAX_PAIRS, {6'd0, n});
    endtask

    initial begin
        int mark;
        int round;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_text("/");
        add_text("A");
        add_text("/%4a%?&k=%7E=%4&z%4");
        add_text("/?a?");
        add_byte(C_SLASH, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        settle();

        steady = 1'b1;
        mark = bytes_queued;
        while (bytes_queued < mark + 110) add_random_url(8, 14);
        settle();
        steady = 1'b0;

        set_limits(12'd1, 12'd4095, 6'd0);
        mark = bytes_queued;
        while (bytes_queued < mark + 70) add_random_url(4, 12);
        settle();

        set_limits(12'd4095, 12'd1, 6'd63);
        mark = bytes_queued;
        while (bytes_queued < mark + 60) add_random_url(6, 4);
        settle();

        for (round = 0; round < 3; round++) begin
            set_limits(12'($urandom_range(1, 8)), 12'($urandom_range(1, 12)),
                       6'($urandom_range(0, 3)));
            mark = bytes_queued;
            while (bytes_queued < mark + 45) add_random_url(8, 14);
            settle();
        end

        settle();
        if (tokens_due.size() != 0)
            note_mismatch("tokens never delivered", tokens_due.size(), 0);
        $display("covered %0d URLs (%0d rejected), %0d bytes in, %0d tokens checked",
                 urls_seen, urls_rejected, bytes_taken, tokens_checked);
        $display("limit settings: reset, tight and loose extremes, random");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/uoft_pkg.sv
sv/uoft_front.sv
sv/uoft_queue.sv
sv/uoft_back.sv
sv/url_origin_form_tokenizer_unit.sv
sim/tb_url_origin_form_tokenizer_unit.sv
